// ===== rtl/core/kct_pkg.sv =====
// ----------------------------------------------------------------------------
// kct_pkg: shared types and constants for the keyed count table
// Table sizing, item and queue types, operation codes and helper functions.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 16;
   localparam int COUNT_BITS  = 32;
   localparam int TOTAL_BITS  = 36;

   localparam int KEY_IN_BITS = 16;
   localparam int AMT_BITS    = 32;
   localparam int CNT_OUT_BITS = 32;

   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CALC_BITS   = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;

   // queue depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_BITS = 48;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 72;

   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_REMOVE = 2'd1,
      FN_SET    = 2'd2,
      FN_QUERY  = 2'd3
   } kct_func_type;

   typedef enum logic [1:0] {
      BK_LOOK = 2'd0,
      BK_DOWN = 2'd1,
      BK_UP   = 2'd2
   } kct_bk_state_type;

   typedef struct packed {
      kct_func_type          func;
      logic [KEY_BITS-1:0]   key;
      logic [AMT_BITS-1:0]   amount;
      logic [COUNT_BITS-1:0] clip;
      logic                  amt_zero;
      logic                  clip_zero;
   } kct_item_type;

   typedef struct packed {
      logic         valid;
      kct_item_type item;
   } kct_head_type;

   function automatic logic [63:0] widen_cnt(input logic [COUNT_BITS-1:0] c);
      logic [63:0] r;
      r = '0;
      r[COUNT_BITS-1:0] = c;
      return r;
   endfunction

   function automatic logic [KEY_BITS-1:0] key_of(input logic [KEY_IN_BITS-1:0] k);
      logic [63:0] w;
      w = '0;
      w[KEY_IN_BITS-1:0] = k;
      return w[KEY_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] clip_of(input logic [AMT_BITS-1:0] a);
      logic [63:0] a64;
      logic [63:0] cmax;
      logic [63:0] c64;
      a64 = '0;
      a64[AMT_BITS-1:0] = a;
      cmax = {64{1'b1}} >> (64 - COUNT_BITS);
      c64 = (a64 > cmax) ? cmax : a64;
      return c64[COUNT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/kct_front.sv =====
// ----------------------------------------------------------------------------
// kct_front: request intake
// Accepts request words, decodes the key and amount, pushes them to the queue.
// ----------------------------------------------------------------------------
module kct_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] item_key, [47:16] amount
   input  logic [kct_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] func
   input  logic [kct_pkg::REQ_USER_BITS-1:0] req_tuser,
   input  logic                              q_not_full,
   output logic                              push,
   output kct_pkg::kct_item_type             push_item
);
   import kct_pkg::*;

   logic [AMT_BITS-1:0] amt;

   assign amt        = req_tdata[KEY_IN_BITS +: AMT_BITS];
   assign req_tready = q_not_full;
   assign push       = req_tvalid && q_not_full;

   always_comb begin
      push_item.func      = kct_func_type'(req_tuser);
      push_item.key       = key_of(req_tdata[KEY_IN_BITS-1:0]);
      push_item.amount    = amt;
      push_item.clip      = clip_of(amt);
      push_item.amt_zero  = (amt == '0);
      push_item.clip_zero = (clip_of(amt) == '0);
   end

endmodule

// ===== rtl/core/kct_queue.sv =====
// ----------------------------------------------------------------------------
// kct_queue: short queue between intake and table engine
// ----------------------------------------------------------------------------
module kct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kct_pkg::kct_item_type push_item,
   output logic                  q_not_full,
   input  logic                  pop,
   output kct_pkg::kct_head_type head
);
   import kct_pkg::*;

   kct_item_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   level_ff, level_in;

   assign q_not_full = (level_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign head.valid = (level_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/kct_back.sv =====
// ----------------------------------------------------------------------------
// kct_back: table engine
// Key lookup, count update and running total, then the response register.
// ----------------------------------------------------------------------------
module kct_back (
   input  logic                              clock,
   input  logic                              reset,
   input  kct_pkg::kct_head_type             head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] count_now, [67:32] total_now, [68] satisfied, [69] status, [71:70] zero
   output logic [kct_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import kct_pkg::*;

   kct_bk_state_type      state_ff, state_in;

   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_ff  [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

   kct_item_type          cur_ff;
   logic                  hit_ff, has_free_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff, free_idx_ff;
   logic [COUNT_BITS-1:0] old_cnt_ff;

   logic [TOTAL_BITS-1:0] total_ff;
   logic [COUNT_BITS-1:0] inc_ff;
   logic [COUNT_BITS-1:0] res_cnt_ff;
   logic                  res_sat_ff, res_stat_ff;

   logic                  out_valid_ff;
   logic [RSP_DATA_BITS-1:0] out_data_ff;

   // lookup
   logic [ENTRIES-1:0]    match;
   logic                  lk_hit, lk_free;
   logic [IDX_BITS-1:0]   lk_hit_idx, lk_free_idx;

   // update decision
   logic                  wr_en, set_valid, clr_valid;
   logic [IDX_BITS-1:0]   wr_idx;
   logic [COUNT_BITS-1:0] new_cnt, dec, inc, res_cnt, room, add_d, rem_d;
   logic                  sat, stat;
   logic [63:0]           a64, o64;

   logic [CALC_BITS-1:0]  t_calc, d_calc, up_calc, tmax_calc;
   logic [TOTAL_BITS-1:0] total_dn, total_upd;
   logic                  fire;
   logic [63:0]           res_cnt64;

   always_comb begin
      lk_hit      = 1'b0;
      lk_free     = 1'b0;
      lk_hit_idx  = '0;
      lk_free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_ff[i] == head.item.key);
         if (match[i]) begin
            lk_hit     = 1'b1;
            lk_hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            lk_free     = 1'b1;
            lk_free_idx = IDX_BITS'(i);
         end
      end
   end

   assign pop  = (state_ff == BK_LOOK) && head.valid;
   assign fire = !out_valid_ff || rsp_tready;

   always_comb begin
      case (state_ff)
         BK_LOOK: state_in = head.valid ? BK_DOWN : BK_LOOK;
         BK_DOWN: state_in = BK_UP;
         BK_UP:   state_in = fire ? BK_LOOK : BK_UP;
         default: state_in = BK_LOOK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_LOOK;
      end else begin
         state_ff <= state_in;
      end
   end

   assign a64   = {32'd0, cur_ff.amount};
   assign o64   = widen_cnt(old_cnt_ff);
   assign room  = ~old_cnt_ff;
   assign add_d = hit_ff ? ((cur_ff.clip > room) ? room : cur_ff.clip) : cur_ff.clip;
   assign rem_d = (a64 < o64) ? a64[COUNT_BITS-1:0] : old_cnt_ff;

   always_comb begin
      wr_en     = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      wr_idx    = hit_idx_ff;
      new_cnt   = old_cnt_ff;
      dec       = '0;
      inc       = '0;
      res_cnt   = hit_ff ? old_cnt_ff : '0;
      sat       = 1'b0;
      stat      = STAT_DONE;
      case (cur_ff.func)
         FN_ADD: begin
            if (!cur_ff.amt_zero) begin
               if (hit_ff) begin
                  wr_en   = 1'b1;
                  new_cnt = old_cnt_ff + add_d;
                  inc     = add_d;
                  res_cnt = old_cnt_ff + add_d;
               end else if (has_free_ff) begin
                  wr_en     = 1'b1;
                  set_valid = 1'b1;
                  wr_idx    = free_idx_ff;
                  new_cnt   = add_d;
                  inc       = add_d;
                  res_cnt   = add_d;
               end else begin
                  stat = STAT_FULL;
               end
            end
         end
         FN_REMOVE: begin
            if (!cur_ff.amt_zero && hit_ff) begin
               wr_en   = 1'b1;
               new_cnt = old_cnt_ff - rem_d;
               dec     = rem_d;
               res_cnt = old_cnt_ff - rem_d;
               if (old_cnt_ff == rem_d) begin
                  clr_valid = 1'b1;
               end
            end
         end
         FN_SET: begin
            if (hit_ff) begin
               wr_en   = 1'b1;
               new_cnt = cur_ff.clip;
               dec     = old_cnt_ff;
               inc     = cur_ff.clip;
               res_cnt = cur_ff.clip;
               clr_valid = cur_ff.clip_zero;
            end else if (!cur_ff.clip_zero) begin
               if (has_free_ff) begin
                  wr_en     = 1'b1;
                  set_valid = 1'b1;
                  wr_idx    = free_idx_ff;
                  new_cnt   = cur_ff.clip;
                  inc       = cur_ff.clip;
                  res_cnt   = cur_ff.clip;
               end else begin
                  stat = STAT_FULL;
               end
            end
         end
         FN_QUERY: begin
            sat = cur_ff.amt_zero || (hit_ff && (o64 >= a64));
         end
         default: begin
            sat = 1'b0;
         end
      endcase
   end

   // running total: subtract in the update cycle, add in the response cycle
   assign t_calc    = CALC_BITS'(total_ff);
   assign d_calc    = CALC_BITS'(dec);
   assign total_dn  = (t_calc >= d_calc) ? TOTAL_BITS'(t_calc - d_calc) : '0;
   assign tmax_calc = CALC_BITS'({TOTAL_BITS{1'b1}});
   assign up_calc   = t_calc + CALC_BITS'(inc_ff);
   assign total_upd = (up_calc > tmax_calc) ? {TOTAL_BITS{1'b1}} : TOTAL_BITS'(up_calc);
   assign res_cnt64 = widen_cnt(res_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == BK_DOWN) begin
            total_ff <= total_dn;
            if (set_valid) begin
               valid_ff[wr_idx] <= 1'b1;
            end else if (clr_valid) begin
               valid_ff[wr_idx] <= 1'b0;
            end
         end else if ((state_ff == BK_UP) && fire) begin
            total_ff <= total_upd;
         end
         if ((state_ff == BK_UP) && fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff      <= head.item;
         hit_ff      <= lk_hit;
         has_free_ff <= lk_free;
         hit_idx_ff  <= lk_hit_idx;
         free_idx_ff <= lk_free_idx;
         old_cnt_ff  <= cnt_mem[lk_hit_idx];
      end
      if ((state_ff == BK_DOWN) && wr_en) begin
         cnt_mem[wr_idx] <= new_cnt;
      end
      if ((state_ff == BK_DOWN) && set_valid) begin
         key_ff[wr_idx] <= cur_ff.key;
      end
      if (state_ff == BK_DOWN) begin
         inc_ff      <= inc;
         res_cnt_ff  <= res_cnt;
         res_sat_ff  <= sat;
         res_stat_ff <= stat;
      end
      if ((state_ff == BK_UP) && fire) begin
         out_data_ff <= {2'b00, res_stat_ff, res_sat_ff, total_upd,
                         res_cnt64[CNT_OUT_BITS-1:0]};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/core/keyed_count_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_count_table_top: bounded key/quantity table with running total
// Add, remove, set and query of per-key counts; one response per request.
// ----------------------------------------------------------------------------
// Each request word yields exactly one response word, in order. The intake
// side takes a word per cycle while the two-deep queue has room; the table
// engine then handles each word in steps (key lookup with count read, count
// update with total subtract, total add into the response register) and takes
// a new word only after the last one, whose final step waits on rsp_tready. Key
// lookup compares all entries in parallel; a new key takes the lowest free entry,
// and an add or set of a new key with no free entry is dropped with status set.
module keyed_count_table_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] item_key, [47:16] amount
   input  logic [kct_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] func
   input  logic [kct_pkg::REQ_USER_BITS-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] count_now, [67:32] total_now, [68] satisfied, [69] status, [71:70] zero
   output logic [kct_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import kct_pkg::*;

   logic         q_not_full;
   logic         push;
   logic         pop;
   kct_item_type push_item;
   kct_head_type head;

   kct_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_not_full (q_not_full),
      .push       (push),
      .push_item  (push_item)
   );

   kct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .q_not_full (q_not_full),
      .pop        (pop),
      .head       (head)
   );

   kct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> head.valid)
      else $error("queue empty after accepted request");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[69]) |-> (rsp_tdata[31:0] == '0))
      else $error("dropped request reports nonzero count");

   a_full_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[68] && rsp_tdata[69]))
      else $error("satisfied and full both set");

endmodule

// ===== test/keyed_count_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_count_table_top_test: self-checking bench for the keyed count table
// Drives add, remove, set and query words with random gaps and response
// stalls, tracks the table and running total in a local shadow, and checks
// every response word field by field in order.
// ----------------------------------------------------------------------------
module keyed_count_table_top_test;

   import kct_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          KEY_POOL    = 22;
   localparam logic [63:0] COUNT_MAX   = {64{1'b1}} >> (64 - COUNT_BITS);
   localparam logic [63:0] TOTAL_MAX   = {64{1'b1}} >> (64 - TOTAL_BITS);

   typedef struct {
      logic [CNT_OUT_BITS-1:0] count_now;
      logic [TOTAL_BITS-1:0]   total_now;
      logic                    satisfied;
      logic                    status;
   } reply_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_USER_BITS-1:0] req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // shadow of the table
   logic                  tally_valid [ENTRIES];
   logic [KEY_BITS-1:0]   tally_key   [ENTRIES];
   logic [COUNT_BITS-1:0] tally_count [ENTRIES];
   logic [TOTAL_BITS-1:0] tally_total;

   reply_type     pending_replies[$];
   logic [15:0]   key_pool[KEY_POOL];
   int            mismatches    = 0;
   int            req_gap_max   = 10;
   int            rsp_stall_max = 10;
   longint        cycle_count   = 0;

   keyed_count_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int find_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (tally_valid[i] && tally_key[i] == key)
            return i;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (!tally_valid[i])
            return i;
      return -1;
   endfunction

   function automatic void raise_total(logic [63:0] d);
      if (d > TOTAL_MAX - 64'(tally_total))
         tally_total = TOTAL_MAX[TOTAL_BITS-1:0];
      else
         tally_total = tally_total + d[TOTAL_BITS-1:0];
   endfunction

   function automatic void lower_total(logic [63:0] d);
      if (d > 64'(tally_total))
         tally_total = '0;
      else
         tally_total = tally_total - d[TOTAL_BITS-1:0];
   endfunction

   // applies one request to the shadow table and returns the reply it yields
   function automatic reply_type apply_request(kct_func_type fn, logic [15:0] key_in,
                                               logic [31:0] amt);
      logic [KEY_BITS-1:0] key;
      logic [63:0]         clip;
      logic [63:0]         room;
      logic [63:0]         delta;
      int                  slot;
      int                  spare;
      reply_type           r;
      key = key_in[KEY_BITS-1:0];
      clip = (64'(amt) > COUNT_MAX) ? COUNT_MAX : 64'(amt);
      r.satisfied = 1'b0;
      r.status = STAT_DONE;
      slot = find_slot(key);
      case (fn)
         FN_ADD: begin
            if (amt != 0) begin
               if (slot < 0) begin
                  spare = free_slot();
                  if (spare < 0) begin
                     r.status = STAT_FULL;
                  end else begin
                     tally_valid[spare] = 1'b1;
                     tally_key[spare] = key;
                     tally_count[spare] = '0;
                     slot = spare;
                  end
               end
               if (slot >= 0) begin
                  room = COUNT_MAX - 64'(tally_count[slot]);
                  delta = (clip > room) ? room : clip;
                  tally_count[slot] = tally_count[slot] + delta[COUNT_BITS-1:0];
                  raise_total(delta);
               end
            end
         end
         FN_REMOVE: begin
            if (amt != 0 && slot >= 0) begin
               delta = (64'(amt) < 64'(tally_count[slot])) ? 64'(amt)
                                                           : 64'(tally_count[slot]);
               tally_count[slot] = tally_count[slot] - delta[COUNT_BITS-1:0];
               lower_total(delta);
               if (tally_count[slot] == 0)
                  tally_valid[slot] = 1'b0;
            end
         end
         FN_SET: begin
            if (slot >= 0) begin
               lower_total(64'(tally_count[slot]));
               raise_total(clip);
               tally_count[slot] = clip[COUNT_BITS-1:0];
               if (clip == 0)
                  tally_valid[slot] = 1'b0;
            end else if (clip != 0) begin
               spare = free_slot();
               if (spare < 0) begin
                  r.status = STAT_FULL;
               end else begin
                  tally_valid[spare] = 1'b1;
                  tally_key[spare] = key;
                  tally_count[spare] = clip[COUNT_BITS-1:0];
                  raise_total(clip);
               end
            end
         end
         default: begin
            if (amt == 0)
               r.satisfied = 1'b1;
            else if (slot >= 0 && 64'(tally_count[slot]) >= 64'(amt))
               r.satisfied = 1'b1;
         end
      endcase
      slot = find_slot(key);
      r.count_now = (slot >= 0) ? CNT_OUT_BITS'(tally_count[slot]) : '0;
      r.total_now = tally_total;
      return r;
   endfunction

   task automatic send_word(kct_func_type fn, logic [15:0] key, logic [31:0] amt);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {amt, key};
      req_tuser  <= fn;
      do @(posedge clock); while (!req_tready);
      pending_replies.push_back(apply_request(fn, key, amt));
   endtask

   // response side stalls
   always begin
      int stall;
      @(negedge clock);
      stall = $urandom_range(0, rsp_stall_max);
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
   end

   task automatic report_mismatch(string name, logic [63:0] want, logic [63:0] got);
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : reply_check
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("response word with nothing pending: 0x%0h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[31:0] !== want.count_now)
               report_mismatch("count_now", 64'(want.count_now), 64'(rsp_tdata[31:0]));
            if (rsp_tdata[67:32] !== want.total_now)
               report_mismatch("total_now", 64'(want.total_now), 64'(rsp_tdata[67:32]));
            if (rsp_tdata[68] !== want.satisfied)
               report_mismatch("satisfied", 64'(want.satisfied), 64'(rsp_tdata[68]));
            if (rsp_tdata[69] !== want.status)
               report_mismatch("status", 64'(want.status), 64'(rsp_tdata[69]));
         end
      end
   end

   function automatic logic [31:0] pick_amount();
      case ($urandom_range(0, 9))
         0:          return 32'h0;
         1, 2, 3, 4: return $urandom_range(1, 40);
         5:          return 32'hFFFF_FFFF;
         6:          return 32'hFFFF_FFFF - $urandom_range(0, 40);
         default:    return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_key();
      logic [31:0] r;
      r = $urandom();
      if ($urandom_range(0, 9) == 0)
         return r[15:0];
      return key_pool[$urandom_range(0, KEY_POOL - 1)];
   endfunction

   task automatic run_random_words(int n);
      for (int i = 0; i < n; i++)
         send_word(kct_func_type'($urandom_range(0, 3)), pick_key(), pick_amount());
   endtask

   // zero amounts, missing keys, saturation, partial and full removes
   task automatic test_special_cases();
      send_word(FN_ADD,    16'h0000, 32'h0);
      send_word(FN_REMOVE, 16'h0000, 32'd5);
      send_word(FN_SET,    16'h0000, 32'h0);
      send_word(FN_QUERY,  16'h0000, 32'h0);
      send_word(FN_QUERY,  16'h0000, 32'd1);
      send_word(FN_ADD,    16'h0000, 32'd7);
      send_word(FN_ADD,    16'hFFFF, 32'hFFFF_FFFF);
      send_word(FN_ADD,    16'hFFFF, 32'd3);
      send_word(FN_QUERY,  16'hFFFF, 32'hFFFF_FFFF);
      send_word(FN_REMOVE, 16'h0000, 32'h0);
      send_word(FN_REMOVE, 16'h0000, 32'd3);
      send_word(FN_QUERY,  16'h0000, 32'd5);
      send_word(FN_QUERY,  16'h0000, 32'd4);
      send_word(FN_REMOVE, 16'h0000, 32'd100);
      send_word(FN_SET,    16'hFFFF, 32'd12);
      send_word(FN_SET,    16'hFFFF, 32'h0);
      send_word(FN_SET,    16'hA5A5, 32'h5A5A_5A5A);
      send_word(FN_ADD,    16'h5A5A, 32'hA5A5_A5A5);
   endtask

   // fill every entry, hit the full case, free one and reuse it, then drain
   task automatic test_table_full();
      logic [15:0] live[$];
      for (int i = 0; i < ENTRIES; i++)
         send_word(FN_ADD, 16'h1000 + 16'(i), 32'(i + 1));
      send_word(FN_ADD,    16'h2222, 32'd9);
      send_word(FN_SET,    16'h2222, 32'd9);
      send_word(FN_SET,    16'h2222, 32'h0);
      send_word(FN_ADD,    16'h2222, 32'h0);
      send_word(FN_QUERY,  16'h2222, 32'd1);
      send_word(FN_REMOVE, 16'h1003, 32'hFFFF_FFFF);
      send_word(FN_ADD,    16'h2222, 32'd9);
      send_word(FN_SET,    16'h3333, 32'd1);
      for (int i = 0; i < ENTRIES; i++)
         if (tally_valid[i])
            live.push_back(16'(tally_key[i]));
      foreach (live[i])
         send_word(FN_SET, live[i], 32'h0);
   endtask

   task automatic test_random_traffic();
      run_random_words(150);
      foreach (key_pool[i])
         key_pool[i] = 16'($urandom());
      run_random_words(150);
   endtask

   task automatic test_streaming_burst();
      req_gap_max = 0;
      rsp_stall_max = 0;
      run_random_words(100);
      req_gap_max = 10;
      rsp_stall_max = 10;
   endtask

   initial begin
      foreach (tally_valid[i])
         tally_valid[i] = 1'b0;
      tally_total = '0;
      foreach (key_pool[i])
         key_pool[i] = 16'($urandom());
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_table_full();
      test_random_traffic();
      test_streaming_burst();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
